@@ rtl/core/rbb_pkg.sv @@
package rbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int WID_W      = 12;
  localparam int HGT_W      = 16;
  localparam int ROW_W      = HGT_W + 1;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int NUM_W      = SUM_W + 1;
  localparam int RCP_SHIFT  = 18;
  localparam int RCP_W      = RCP_SHIFT;
  localparam int RCP_ONE    = 1 << RCP_SHIFT;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  // one step of the window sequencer, as it travels with the row store read
  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic [PIX_W-1:0]  pix;
    logic              wr;
    logic              emit;
    logic              lft_ok;
    logic              rgt_ok;
    logic              top_ok;
    logic              bot_ok;
    logic              last;
  } step_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } sum_t;

  // ceil(2^RCP_SHIFT / (2*cnt)), exact for every numerator the window can give
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      4'd1:    r = RCP_W'((RCP_ONE + 1) / 2);
      4'd2:    r = RCP_W'((RCP_ONE + 3) / 4);
      4'd3:    r = RCP_W'((RCP_ONE + 5) / 6);
      4'd4:    r = RCP_W'((RCP_ONE + 7) / 8);
      4'd5:    r = RCP_W'((RCP_ONE + 9) / 10);
      4'd6:    r = RCP_W'((RCP_ONE + 11) / 12);
      4'd7:    r = RCP_W'((RCP_ONE + 13) / 14);
      4'd8:    r = RCP_W'((RCP_ONE + 15) / 16);
      4'd9:    r = RCP_W'((RCP_ONE + 17) / 18);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/rbb_line_mem.sv @@
module rbb_line_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [rbb_pkg::ADDR_W-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [rbb_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [rbb_pkg::PIX_W-1:0]     wr_pix,
  output logic [rbb_pkg::PIX_W-1:0]     near_q,
  output logic [rbb_pkg::PIX_W-1:0]     far_q
);

  logic [rbb_pkg::PIX_W-1:0] near_mem [rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0] far_mem  [rbb_pkg::MAX_WIDTH];

  logic [rbb_pkg::PIX_W-1:0] near_rd_r;
  logic [rbb_pkg::PIX_W-1:0] far_rd_r;
  logic                      fwd_hit_r;
  logic [rbb_pkg::PIX_W-1:0] fwd_near_r;
  logic [rbb_pkg::PIX_W-1:0] fwd_far_r;

  // near row shifts into the far row on every write of a column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      near_mem[wr_addr] <= wr_pix;
      far_mem[wr_addr]  <= near_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      near_rd_r  <= near_mem[rd_addr];
      far_rd_r   <= far_mem[rd_addr];
      fwd_near_r <= wr_pix;
      fwd_far_r  <= near_q;
    end
  end

  // a write landing on the same column in the read cycle is forwarded to the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign near_q = fwd_hit_r ? fwd_near_r : near_rd_r;
  assign far_q  = fwd_hit_r ? fwd_far_r  : far_rd_r;

endmodule

@@ rtl/core/rbb_seq.sv @@
module rbb_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [rbb_pkg::PIX_W-1:0]        in_pix,
  input  logic                             cfg_valid,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             rd_en,
  output logic [rbb_pkg::ADDR_W-1:0]       rd_addr,
  output rbb_pkg::step_t                   s1_step,
  output logic                             s1_vld
);

  logic [rbb_pkg::WID_W-1:0]  wid_r;
  logic [rbb_pkg::HGT_W-1:0]  hgt_r;
  logic [rbb_pkg::ADDR_W-1:0] x_r;
  logic [rbb_pkg::ROW_W-1:0]  y_r;
  logic                       extra_r;
  rbb_pkg::step_t             s1_r;
  logic                       s1_vld_r;

  logic [rbb_pkg::ADDR_W-1:0] wm1;
  logic [rbb_pkg::HGT_W-1:0]  h_eff;
  logic [rbb_pkg::ROW_W-1:0]  h_ext;
  logic [rbb_pkg::ROW_W-1:0]  h_p1;
  logic                       fire_in;
  logic                       in_frame;
  logic                       is_real;
  logic                       step_go;
  logic                       x_zero;
  logic                       emit;
  logic                       last;
  rbb_pkg::step_t             step_nxt;
  logic [rbb_pkg::ADDR_W-1:0] x_nxt;
  logic [rbb_pkg::ROW_W-1:0]  y_nxt;

  always_comb begin
    if (wid_r == '0) begin
      wm1 = '0;
    end else if (int'(wid_r) > rbb_pkg::MAX_WIDTH) begin
      wm1 = rbb_pkg::ADDR_W'(rbb_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = rbb_pkg::ADDR_W'(wid_r - 1'b1);
    end
  end

  assign h_eff = (hgt_r == '0) ? rbb_pkg::HGT_W'(1) : hgt_r;
  assign h_ext = {1'b0, h_eff};
  assign h_p1  = h_ext + rbb_pkg::ROW_W'(1);

  assign in_ready = en && !extra_r;
  assign fire_in  = in_valid && in_ready;
  assign in_frame = y_r < h_ext;
  assign is_real  = fire_in && (rbb_pkg::kind_t'(in_kind) == rbb_pkg::KIND_PIXEL) && in_frame;
  // past the last pixel any word drains one result; flushes inside the frame are dropped
  assign step_go  = is_real || (fire_in && !in_frame) || (en && extra_r);

  assign x_zero = (x_r == '0);
  assign emit   = (y_r >= rbb_pkg::ROW_W'(2)) || ((y_r == rbb_pkg::ROW_W'(1)) && !x_zero);
  assign last   = (y_r == h_p1) && x_zero;

  always_comb begin
    step_nxt.col    = x_r;
    step_nxt.pix    = in_pix;
    step_nxt.wr     = is_real;
    step_nxt.emit   = emit;
    step_nxt.last   = last;
    // column zero closes the previous row: window is the last two columns held
    step_nxt.rgt_ok = !x_zero;
    step_nxt.lft_ok = x_zero ? (wm1 != '0) : (x_r >= rbb_pkg::ADDR_W'(2));
    step_nxt.top_ok = x_zero ? (y_r >= rbb_pkg::ROW_W'(3)) : (y_r >= rbb_pkg::ROW_W'(2));
    step_nxt.bot_ok = x_zero ? (y_r < h_p1) : (y_r < h_ext);
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (last) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (x_r == wm1) begin
      x_nxt = '0;
      y_nxt = y_r + rbb_pkg::ROW_W'(1);
    end else begin
      x_nxt = x_r + rbb_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r    <= rbb_pkg::WIDTH_RST;
      hgt_r    <= rbb_pkg::HEIGHT_RST;
      x_r      <= '0;
      y_r      <= '0;
      extra_r  <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (rbb_pkg::cfg_idx_t'(cfg_index))
          rbb_pkg::CFG_WIDTH:  wid_r <= cfg_data[rbb_pkg::WID_W-1:0];
          rbb_pkg::CFG_HEIGHT: hgt_r <= cfg_data[rbb_pkg::HGT_W-1:0];
          default: ;
        endcase
        x_r     <= '0;
        y_r     <= '0;
        extra_r <= 1'b0;
      end else if (step_go) begin
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        // a one-row frame has a silent step before its first result
        extra_r <= !in_frame && !emit;
      end
      if (en) begin
        s1_vld_r <= step_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && step_go) begin
      s1_r <= step_nxt;
    end
  end

  assign rd_en   = en && step_go;
  assign rd_addr = x_r;
  assign s1_step = s1_r;
  assign s1_vld  = s1_vld_r;

endmodule

@@ rtl/core/rbb_win.sv @@
module rbb_win (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      s1_vld,
  input  rbb_pkg::step_t            s1_step,
  input  logic [rbb_pkg::PIX_W-1:0] near_q,
  input  logic [rbb_pkg::PIX_W-1:0] far_q,
  output rbb_pkg::sum_t             sum_o,
  output logic                      sum_vld
);

  typedef struct packed {
    logic [rbb_pkg::PIX_W-1:0] top;
    logic [rbb_pkg::PIX_W-1:0] mid;
    logic [rbb_pkg::PIX_W-1:0] bot;
  } col_t;

  col_t                      colb_r;
  col_t                      colc_r;
  rbb_pkg::sum_t             sum_r;
  logic                      sum_vld_r;

  col_t                      new_col;
  col_t                      win_cols [3];
  logic [2:0]                col_ok;
  logic [2:0]                row_ok;
  logic [rbb_pkg::SUM_W-1:0] col_sum [3][3];
  logic [rbb_pkg::SUM_W-1:0] chan_sum [3];
  logic [1:0]                n_cols;
  logic [1:0]                n_rows;
  rbb_pkg::sum_t             sum_nxt;

  assign new_col = '{top: far_q, mid: near_q, bot: s1_step.pix};

  always_comb begin
    win_cols[0] = colb_r;
    win_cols[1] = colc_r;
    win_cols[2] = new_col;
    col_ok = {s1_step.rgt_ok, 1'b1, s1_step.lft_ok};
    row_ok = {s1_step.bot_ok, 1'b1, s1_step.top_ok};
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        col_sum[ch][c] =
          ((row_ok[0] && col_ok[c]) ?
             rbb_pkg::SUM_W'(win_cols[c].top[ch*rbb_pkg::CH_W +: rbb_pkg::CH_W]) : '0) +
          (col_ok[c] ?
             rbb_pkg::SUM_W'(win_cols[c].mid[ch*rbb_pkg::CH_W +: rbb_pkg::CH_W]) : '0) +
          ((row_ok[2] && col_ok[c]) ?
             rbb_pkg::SUM_W'(win_cols[c].bot[ch*rbb_pkg::CH_W +: rbb_pkg::CH_W]) : '0);
      end
      chan_sum[ch] = col_sum[ch][0] + col_sum[ch][1] + col_sum[ch][2];
    end
    n_cols = 2'd1 + {1'b0, s1_step.lft_ok} + {1'b0, s1_step.rgt_ok};
    n_rows = 2'd1 + {1'b0, s1_step.top_ok} + {1'b0, s1_step.bot_ok};
    sum_nxt.red   = chan_sum[0];
    sum_nxt.green = chan_sum[1];
    sum_nxt.blue  = chan_sum[2];
    sum_nxt.cnt   = rbb_pkg::CNT_W'(n_cols) * rbb_pkg::CNT_W'(n_rows);
    sum_nxt.last  = s1_step.last;
  end

  // every step shifts a column in, emitting or not
  always_ff @(posedge clk) begin
    if (en && s1_vld) begin
      colb_r <= colc_r;
      colc_r <= new_col;
    end
    if (en && s1_vld && s1_step.emit) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (en) begin
      sum_vld_r <= s1_vld && s1_step.emit;
    end
  end

  assign sum_o   = sum_r;
  assign sum_vld = sum_vld_r;

endmodule

@@ rtl/core/rbb_norm.sv @@
module rbb_norm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      sum_vld,
  input  rbb_pkg::sum_t             sum_i,
  output logic                      out_vld,
  output logic [rbb_pkg::PIX_W-1:0] out_pix,
  output logic                      out_last
);

  localparam int PROD_W = rbb_pkg::NUM_W + rbb_pkg::RCP_W;

  logic                      out_vld_r;
  logic [rbb_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_last_r;

  logic [rbb_pkg::SUM_W-1:0] sums [3];
  logic [rbb_pkg::NUM_W-1:0] num [3];
  logic [rbb_pkg::RCP_W-1:0] rcp;
  logic [PROD_W-1:0]         prod [3];
  logic [rbb_pkg::PIX_W-1:0] pix_nxt;

  // (2*sum + cnt) div (2*cnt) as a multiply by a rounded-up reciprocal
  always_comb begin
    sums[0] = sum_i.red;
    sums[1] = sum_i.green;
    sums[2] = sum_i.blue;
    rcp = rbb_pkg::recip(sum_i.cnt);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sums[ch], 1'b0} + rbb_pkg::NUM_W'(sum_i.cnt);
      prod[ch] = PROD_W'(num[ch]) * PROD_W'(rcp);
      pix_nxt[ch*rbb_pkg::CH_W +: rbb_pkg::CH_W] =
        prod[ch][rbb_pkg::RCP_SHIFT +: rbb_pkg::CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en && sum_vld) begin
      out_pix_r  <= pix_nxt;
      out_last_r <= sum_i.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sum_vld;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_pix  = out_pix_r;
  assign out_last = out_last_r;

endmodule

@@ rtl/core/rgb_box_blur_3x3.sv @@
// a result passes the step, sum and output registers after the word that completes its window is taken
// (the pixel one row plus one column later, or a drain word after the frame)
// throughput: one word per cycle unless stalled; a one-row frame's first drain word adds a silent step
// a stalled output holds the whole pipeline; the row stores are read and written at most once a cycle
// reset: positions and counters clear, frame size goes to 640 x 480, row stores keep contents
module rgb_box_blur_3x3 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rbb_pkg::PIX_W-1:0]        in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rbb_pkg::PIX_W-1:0]        out_tdata,  // blur_red, blur_green, blur_blue
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                       en;
  logic                       rd_en;
  logic [rbb_pkg::ADDR_W-1:0] rd_addr;
  rbb_pkg::step_t             s1_step;
  logic                       s1_vld;
  logic [rbb_pkg::PIX_W-1:0]  near_q;
  logic [rbb_pkg::PIX_W-1:0]  far_q;
  rbb_pkg::sum_t              sum_w;
  logic                       sum_vld;

  assign en        = !out_tvalid || out_tready;
  assign cfg_ready = 1'b1;

  rbb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_pix    (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_step   (s1_step),
    .s1_vld    (s1_vld)
  );

  rbb_line_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (en && s1_vld && s1_step.wr),
    .wr_addr (s1_step.col),
    .wr_pix  (s1_step.pix),
    .near_q  (near_q),
    .far_q   (far_q)
  );

  rbb_win u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s1_vld  (s1_vld),
    .s1_step (s1_step),
    .near_q  (near_q),
    .far_q   (far_q),
    .sum_o   (sum_w),
    .sum_vld (sum_vld)
  );

  rbb_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .sum_vld  (sum_vld),
    .sum_i    (sum_w),
    .out_vld  (out_tvalid),
    .out_pix  (out_tdata),
    .out_last (out_tlast)
  );

endmodule
